FILE: rtl/iss_pkg.sv
// ----------------------------------------------------------------------------
// iss_pkg: shared types and constants for interval_schedule_select
// Sizes of the meeting store, the time and position formats, and the word
// held by one sorting cell.
// ----------------------------------------------------------------------------
package iss_pkg;

	// Capacity of the cell chain and width of stored times.
	localparam int MAX_MEETINGS = 64;
	localparam int TIME_WIDTH   = 16;

	// Widths of the channel fields and of the meeting count.
	localparam int IN_TIME_W = 16;
	localparam int POS_W     = 7;
	localparam int COUNT_W   = $clog2(MAX_MEETINGS + 1);

	typedef logic [TIME_WIDTH-1:0] time_t;
	typedef logic [POS_W-1:0]      pos_t;
	typedef logic [COUNT_W-1:0]    count_t;

	// Contents of one sorting cell.
	typedef struct packed {
		logic  valid;
		time_t start;
		time_t fin;
		pos_t  pos;
	} cell_t;

	// Commands broadcast to every cell.
	typedef struct packed {
		logic load;
		logic shift;
	} cell_ctl_t;

	// Controller states.
	localparam logic ST_LOAD = 1'b0;
	localparam logic ST_SCAN = 1'b1;

endpackage

FILE: rtl/iss_channels.sv
// ----------------------------------------------------------------------------
// iss channels: handshake interfaces for meetings and selected positions
// Each word moves when valid and ready are both high at a rising clock edge.
// ----------------------------------------------------------------------------
interface iss_meeting_if;
	logic                         valid;
	logic                         ready;
	logic [iss_pkg::IN_TIME_W-1:0] start_time;
	logic [iss_pkg::IN_TIME_W-1:0] end_time;
	logic                         last_meeting;

	modport source (output valid, start_time, end_time, last_meeting, input ready);
	modport sink   (input valid, start_time, end_time, last_meeting, output ready);
endinterface

interface iss_select_if;
	logic                     valid;
	logic                     ready;
	logic [iss_pkg::POS_W-1:0] position;
	logic                     last_of_run;
	logic                     overflow;

	modport source (output valid, position, last_of_run, overflow, input ready);
	modport sink   (input valid, position, last_of_run, overflow, output ready);
endinterface

FILE: rtl/iss_cell.sv
// ----------------------------------------------------------------------------
// iss_cell: one cell of the insertion-sorting chain
// Holds one meeting. On a load it keeps its meeting, takes the new one or
// takes its lower neighbour's, so the chain stays sorted by end time. On a
// shift it takes its upper neighbour's meeting, moving the chain to cell 0.
// ----------------------------------------------------------------------------
module iss_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  iss_pkg::cell_ctl_t ctl,
	input  iss_pkg::cell_t     ins,
	input  iss_pkg::cell_t     prev,
	input  logic               prev_gt,
	input  iss_pkg::cell_t     next,
	output iss_pkg::cell_t     cur,
	output logic               gt
);
	import iss_pkg::*;

	cell_t cell_q;
	cell_t cell_d;
	logic  take;

	// A held meeting ending strictly later than the new one moves up a place.
	assign gt  = cell_q.valid && (cell_q.fin > ins.fin);
	assign cur = cell_q;

	// Choose the next contents of the cell.
	always_comb begin
		cell_d = cell_q;
		take   = 1'b0;
		if (ctl.shift) begin
			cell_d = next;
			take   = 1'b1;
		end else if (ctl.load) begin
			if (prev_gt) begin
				cell_d = prev;
				take   = 1'b1;
			end else if (gt || (!cell_q.valid && prev.valid)) begin
				cell_d = ins;
				take   = 1'b1;
			end
		end
	end

	// Cell contents; reset leaves the cell empty.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_q <= '0;
		end else if (take) begin
			cell_q <= cell_d;
		end
	end

endmodule

FILE: rtl/iss_ctrl.sv
// ----------------------------------------------------------------------------
// iss_ctrl: load and selection control for interval_schedule_select
// Accepts meetings, numbers them and drives the chain. After the last
// meeting it pops the chain head each cycle unless a selection stall
// holds it, applies the greedy rule and feeds the output register through
// a one-word candidate holding stage so the final selected one is marked.
// ----------------------------------------------------------------------------
module iss_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	iss_meeting_if.sink         meeting,
	iss_select_if.source        selection,
	input  iss_pkg::cell_t      head,
	output iss_pkg::cell_ctl_t  ctl,
	output iss_pkg::cell_t      ins
);
	import iss_pkg::*;

	logic   state_q;
	count_t count_q;
	logic   dropped_q;
	logic   cand_v_q;
	cell_t  cand_q;
	logic   out_v_q;
	pos_t   out_pos_q;
	logic   out_last_q;
	logic   out_ovf_q;

	logic   acc;
	logic   full;
	logic   out_free;
	logic   chosen;
	logic   push;
	logic   push_last;
	logic   done;

	// Input side: meetings are taken only while loading.
	assign meeting.ready = (state_q == ST_LOAD);
	assign acc           = meeting.valid && meeting.ready;
	assign full          = (count_q == count_t'(MAX_MEETINGS));

	// New meeting presented to every cell.
	assign ins.valid = 1'b1;
	assign ins.start = time_t'(meeting.start_time);
	assign ins.fin   = time_t'(meeting.end_time);
	assign ins.pos   = pos_t'(count_q + count_t'(1));

	// Greedy rule: the first head is always chosen, later ones only when
	// they start strictly after the last chosen end.
	assign out_free  = !out_v_q || selection.ready;
	assign chosen    = !cand_v_q || (head.start > cand_q.fin);
	assign ctl.load  = acc && !full;
	assign ctl.shift = (state_q == ST_SCAN) && head.valid
		&& (!chosen || !cand_v_q || out_free);

	// Output words: a displaced candidate, or the final one once the chain
	// has run dry.
	assign push      = (state_q == ST_SCAN) && cand_v_q && out_free
		&& (!head.valid || chosen);
	assign push_last = !head.valid;
	assign done      = (state_q == ST_SCAN) && !head.valid && (out_free || !cand_v_q);

	// Sequencing, counting and drop tracking.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_LOAD;
			count_q   <= '0;
			dropped_q <= 1'b0;
			cand_v_q  <= 1'b0;
		end else begin
			if (acc) begin
				if (full) begin
					dropped_q <= 1'b1;
				end else begin
					count_q <= count_q + count_t'(1);
				end
				if (meeting.last_meeting) begin
					state_q <= ST_SCAN;
				end
			end
			if (ctl.shift && chosen) begin
				cand_v_q <= 1'b1;
			end
			if (done) begin
				state_q   <= ST_LOAD;
				count_q   <= '0;
				dropped_q <= 1'b0;
				cand_v_q  <= 1'b0;
			end
		end
	end

	// Candidate payload.
	always_ff @(posedge clk) begin
		if (ctl.shift && chosen) begin
			cand_q <= head;
		end
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (push) begin
			out_v_q <= 1'b1;
		end else if (selection.ready) begin
			out_v_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (push) begin
			out_pos_q  <= cand_q.pos;
			out_last_q <= push_last;
			out_ovf_q  <= dropped_q;
		end
	end

	assign selection.valid       = out_v_q;
	assign selection.position    = out_pos_q;
	assign selection.last_of_run = out_last_q;
	assign selection.overflow    = out_ovf_q;

	// The chain is never empty when selection starts.
	a_head_at_scan: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(state_q == ST_SCAN) |-> head.valid)
		else $error("chain empty at start of selection");

	// The meeting count never exceeds capacity.
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= count_t'(MAX_MEETINGS))
		else $error("meeting count beyond capacity");

	// A displaced candidate always reaches the output register.
	a_cand_out: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.shift && chosen && cand_v_q) |=> out_v_q)
		else $error("displaced candidate lost");

	// The last meeting always starts selection.
	a_last_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && meeting.last_meeting) |=> (state_q == ST_SCAN))
		else $error("selection not started after last meeting");

endmodule

FILE: rtl/interval_schedule_select.sv
// ----------------------------------------------------------------------------
// interval_schedule_select: greedy interval scheduling over a sorting chain
// Meetings arrive on the meeting channel (start_time, end_time,
// last_meeting); selected arrival positions leave on the selection channel
// (position, last_of_run, overflow).
// Loading takes one meeting per cycle: each word is inserted into a chain of
// MAX_MEETINGS cells kept sorted by end time in the same cycle. Meetings
// beyond capacity are dropped and set overflow on every word of that set.
// The word marked last_meeting starts selection: the chain shifts one cell
// a cycle towards its head, save while the output register is full, not
// taken and a new word is due. The meeting channel is ready again once the
// chain has run dry and the last candidate is in the output register. Each
// position passes through the candidate stage and then the output register.
// While selection runs the meeting channel is not ready. A stall on the
// selection channel holds the output word and pauses the chain only when a
// new word must be written. Reset empties the chain, clears the count and
// the drop flag, and leaves the block ready to load.
// ----------------------------------------------------------------------------
module interval_schedule_select (
	input  logic         clk,
	input  logic         arst_n,
	iss_meeting_if.sink  meeting,
	iss_select_if.source selection
);
	import iss_pkg::*;

	cell_ctl_t ctl;
	cell_t     ins;
	cell_t     cells [MAX_MEETINGS];
	logic      gts   [MAX_MEETINGS];

	// Controller with output register.
	iss_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.meeting   (meeting),
		.selection (selection),
		.head      (cells[0]),
		.ctl       (ctl),
		.ins       (ins)
	);

	// Chain of sorting cells, cell 0 holding the earliest end time.
	for (genvar i = 0; i < MAX_MEETINGS; i++) begin : g_cell
		cell_t prev_c;
		logic  prev_gt_c;
		cell_t next_c;

		if (i == 0) begin : g_first
			assign prev_c    = ins;
			assign prev_gt_c = 1'b0;
		end else begin : g_inner
			assign prev_c    = cells[i-1];
			assign prev_gt_c = gts[i-1];
		end

		if (i == MAX_MEETINGS - 1) begin : g_top
			assign next_c = '0;
		end else begin : g_below
			assign next_c = cells[i+1];
		end

		iss_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.ins     (ins),
			.prev    (prev_c),
			.prev_gt (prev_gt_c),
			.next    (next_c),
			.cur     (cells[i]),
			.gt      (gts[i])
		);
	end

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for interval_schedule_select
// Meeting sets are fed through the meeting channel with random gaps, and
// every selected position is checked against a greedy scheduler kept in the
// bench. Directed sets cover the extremes first. Random sets follow, with a
// full chain, an overflowing chain and pauses until the block has drained.
// ----------------------------------------------------------------------------
module testbench;
	import iss_pkg::*;

	localparam int MEETING_TARGET = 380;
	localparam int IDLE_PERCENT   = 21;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int REPORT_LIMIT   = 10;
	localparam int CALM_FIRST     = 200;
	localparam int CALM_LAST      = 260;
	localparam int TAIL_CYCLES    = 80;

	// One meeting waiting to be offered; drain holds it back until the
	// block has returned every expected position.
	typedef struct {
		logic [IN_TIME_W-1:0] opens;
		logic [IN_TIME_W-1:0] closes;
		logic                 last;
		logic                 drain;
	} meeting_item_t;

	// One expected word on the selection channel.
	typedef struct packed {
		pos_t position;
		logic last_of_run;
		logic overflow;
	} pick_t;

	logic clk = 1'b0;
	logic arst_n;

	iss_meeting_if meeting ();
	iss_select_if  selection ();

	interval_schedule_select dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.meeting   (meeting),
		.selection (selection)
	);

	meeting_item_t meeting_queue[$];
	meeting_item_t next_meeting;
	pick_t         pending_picks[$];
	pick_t         wanted_pick;
	pick_t         seen_pick;

	// Scheduler state: meetings held sorted by end time.
	time_t sorted_start [MAX_MEETINGS];
	time_t sorted_end   [MAX_MEETINGS];
	pos_t  sorted_pos   [MAX_MEETINGS];
	int    held_count = 0;
	logic  dropped    = 1'b0;

	int accepted_meetings = 0;
	int failures          = 0;
	int stall_cycles      = 0;
	logic calm;

	assign calm = (accepted_meetings >= CALM_FIRST) && (accepted_meetings < CALM_LAST);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Insert one meeting into the sorted store; a meeting marked last then
	// runs the greedy pass and queues the positions it picks.
	task automatic schedule_meeting(input logic [IN_TIME_W-1:0] opens,
			input logic [IN_TIME_W-1:0] closes, input logic last);
		int    k;
		int    picked;
		time_t s;
		time_t e;
		time_t chosen_end;
		pick_t pick;
		s = time_t'(opens);
		e = time_t'(closes);
		if (held_count < MAX_MEETINGS) begin
			k = held_count;
			while (k > 0 && sorted_end[k-1] > e) begin
				sorted_start[k] = sorted_start[k-1];
				sorted_end[k]   = sorted_end[k-1];
				sorted_pos[k]   = sorted_pos[k-1];
				k--;
			end
			sorted_start[k] = s;
			sorted_end[k]   = e;
			sorted_pos[k]   = pos_t'(held_count + 1);
			held_count++;
		end else begin
			dropped = 1'b1;
		end
		if (last) begin
			picked     = 0;
			chosen_end = '0;
			for (int i = 0; i < held_count; i++) begin
				if (i == 0 || sorted_start[i] > chosen_end) begin
					pick.position    = sorted_pos[i];
					pick.last_of_run = 1'b0;
					pick.overflow    = dropped;
					pending_picks.insert(pending_picks.size(), pick);
					chosen_end = sorted_end[i];
					picked++;
				end
			end
			if (picked > 0)
				pending_picks[pending_picks.size()-1].last_of_run = 1'b1;
			held_count = 0;
			dropped    = 1'b0;
		end
	endtask

	task automatic queue_meeting(input int opens, input int closes, input bit last,
			input bit drain = 1'b0);
		meeting_item_t item;
		item.opens  = opens[IN_TIME_W-1:0];
		item.closes = closes[IN_TIME_W-1:0];
		item.last   = last;
		item.drain  = drain;
		meeting_queue.insert(meeting_queue.size(), item);
	endtask

	task automatic report_slip(input string what);
		failures++;
		if (failures <= REPORT_LIMIT)
			$display("[%0t] mismatch: %s", $realtime, what);
	endtask

	// Meeting driver: a word stays up until it is taken, then the next one
	// follows unless this cycle idles or a drain pause is due.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meeting.valid        <= 1'b0;
			meeting.start_time   <= '0;
			meeting.end_time     <= '0;
			meeting.last_meeting <= 1'b0;
		end else begin
			if (meeting.valid && meeting.ready) begin
				schedule_meeting(meeting.start_time, meeting.end_time, meeting.last_meeting);
				accepted_meetings <= accepted_meetings + 1;
			end
			if (!meeting.valid || meeting.ready) begin
				if (meeting_queue.size() > 0
						&& (calm || $urandom_range(99) >= IDLE_PERCENT)
						&& !(meeting_queue[0].drain && pending_picks.size() > 0)) begin
					next_meeting = meeting_queue.pop_front();
					meeting.valid        <= 1'b1;
					meeting.start_time   <= next_meeting.opens;
					meeting.end_time     <= next_meeting.closes;
					meeting.last_meeting <= next_meeting.last;
				end else begin
					meeting.valid <= 1'b0;
				end
			end
		end
	end

	// Selection monitor: each word taken is checked against the oldest
	// expected pick, and ready is dropped at random.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			selection.ready <= 1'b0;
		end else begin
			if (selection.valid && selection.ready) begin
				seen_pick.position    = selection.position;
				seen_pick.last_of_run = selection.last_of_run;
				seen_pick.overflow    = selection.overflow;
				if (pending_picks.size() == 0) begin
					report_slip($sformatf("unexpected word position=%0d last=%0b overflow=%0b",
						seen_pick.position, seen_pick.last_of_run, seen_pick.overflow));
				end else begin
					wanted_pick = pending_picks.pop_front();
					if (seen_pick.position !== wanted_pick.position
							|| seen_pick.last_of_run !== wanted_pick.last_of_run
							|| seen_pick.overflow !== wanted_pick.overflow)
						report_slip($sformatf(
							"expected position=%0d last=%0b overflow=%0b, got %0d %0b %0b",
							wanted_pick.position, wanted_pick.last_of_run,
							wanted_pick.overflow, seen_pick.position,
							seen_pick.last_of_run, seen_pick.overflow));
				end
			end
			selection.ready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
		end
	end

	// Watchdog: too long without a word on either channel ends the run.
	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if ((meeting.valid && meeting.ready) || (selection.valid && selection.ready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no word moved for %0d cycles", stall_cycles);
				$display("** interval_schedule_select: FAILED **");
				$finish;
			end
		end
	end

	// Stimulus, reset and end of run.
	initial begin
		int queued;
		int set_index;
		int set_size;
		int mode;
		int base;
		int opens;
		int closes;

		arst_n = 1'b0;

		// Single meetings at the extremes, including a start after its end.
		queue_meeting(0, 0, 1'b1);
		queue_meeting(16'hFFFF, 0, 1'b1);
		queue_meeting(16'hFFFF, 16'hFFFF, 1'b1);
		// A start equal to the chosen end is not picked; equal ends keep
		// arrival order; the last word is sorted in before the pass.
		queue_meeting(10, 20, 1'b0);
		queue_meeting(20, 30, 1'b0);
		queue_meeting(21, 40, 1'b0);
		queue_meeting(5, 20, 1'b0);
		queue_meeting(0, 16'hFFFF, 1'b0);
		queue_meeting(0, 8, 1'b1);
		// Ties on the end time, the first held back by a drain pause.
		queue_meeting(100, 50, 1'b0, 1'b1);
		queue_meeting(0, 50, 1'b0);
		queue_meeting(51, 50, 1'b1);
		// Bit patterns and the top of the range.
		queue_meeting(16'h5555, 16'hAAAA, 1'b0);
		queue_meeting(16'hAAAA, 16'h5555, 1'b0);
		queue_meeting(16'h8000, 16'h7FFF, 1'b0);
		queue_meeting(16'hFFFE, 16'hFFFE, 1'b0);
		queue_meeting(16'hFFFF, 16'hFFFF, 1'b1);
		queued = meeting_queue.size();

		// Random sets: mostly small, one that fills the chain exactly and
		// one that overflows it with a dropped word marked last.
		set_index = 0;
		while (queued < MEETING_TARGET) begin
			case (set_index)
				4:       set_size = MAX_MEETINGS;
				9:       set_size = MAX_MEETINGS + 2;
				default: set_size = $urandom_range(10, 1);
			endcase
			mode = $urandom_range(2);
			base = $urandom_range(65000);
			for (int j = 0; j < set_size; j++) begin
				case (mode)
					0: begin
						opens  = $urandom_range(16'hFFFF);
						closes = $urandom_range(16'hFFFF);
					end
					1: begin
						opens  = base + $urandom_range(300);
						closes = opens + $urandom_range(60);
					end
					default: begin
						opens  = $urandom_range(16'hFFFF, 65400);
						closes = $urandom_range(16'hFFFF, 65450);
					end
				endcase
				if (opens > 16'hFFFF)
					opens = 16'hFFFF;
				if (closes > 16'hFFFF)
					closes = 16'hFFFF;
				queue_meeting(opens, closes, j == set_size - 1, j == 0 && set_index % 9 == 5);
			end
			queued += set_size;
			set_index++;
		end

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (meeting_queue.size() > 0 || meeting.valid)
			@(posedge clk);
		while (pending_picks.size() > 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (failures == 0 && pending_picks.size() == 0)
			$display("** interval_schedule_select: PASSED **");
		else
			$display("** interval_schedule_select: FAILED **");
		$finish;
	end

endmodule
